// File: src/etd_pkg.sv
package etd_pkg;

	// decoded bytes produced by one input byte travel together as a group
	localparam int unsigned GRP_MAX = 4;
	localparam int unsigned GCW = $clog2(GRP_MAX + 1);
	localparam int unsigned GIW = $clog2(GRP_MAX);

	localparam int unsigned QUEUE_DEPTH_DEF = 4;

	// escape syntax
	localparam logic [7:0] CH_BSL   = 8'h5c;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_LC_N  = 8'h6e;
	localparam logic [7:0] CH_LC_R  = 8'h72;
	localparam logic [7:0] CH_LC_T  = 8'h74;
	localparam logic [7:0] CH_LC_E  = 8'h65;
	localparam logic [7:0] CH_LC_X  = 8'h78;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_SEVEN = 8'h37;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_LC_A  = 8'h61;
	localparam logic [7:0] CH_LC_F  = 8'h66;
	localparam logic [7:0] CH_UC_A  = 8'h41;
	localparam logic [7:0] CH_UC_F  = 8'h46;
	localparam logic [7:0] BYTE_LF  = 8'h0a;
	localparam logic [7:0] BYTE_CR  = 8'h0d;
	localparam logic [7:0] BYTE_TAB = 8'h09;
	localparam logic [7:0] BYTE_ESC = 8'h1b;

	// utf-8 byte classes
	localparam logic [7:0] ASCII_MAX = 8'h7f;
	localparam logic [7:0] LEAD2_MIN = 8'hc2;
	localparam logic [7:0] LEAD2_MAX = 8'hdf;
	localparam logic [7:0] LEAD3_MIN = 8'he0;
	localparam logic [7:0] LEAD3_MAX = 8'hef;
	localparam logic [7:0] LEAD4_MIN = 8'hf0;
	localparam logic [7:0] LEAD4_MAX = 8'hf4;
	localparam logic [7:0] CONT_MASK = 8'hc0;
	localparam logic [7:0] CONT_TAG  = 8'h80;
	localparam logic [7:0] CONT_BITS = 8'h3f;

	// code point limits
	localparam int unsigned CPW = 21;
	localparam logic [CPW-1:0] CP_MIN3 = 21'h000800;
	localparam logic [CPW-1:0] CP_MIN4 = 21'h010000;
	localparam logic [CPW-1:0] SURR_LO = 21'h00d800;
	localparam logic [CPW-1:0] SURR_HI = 21'h00dfff;
	localparam logic [CPW-1:0] CP_MAX  = 21'h10ffff;

	typedef struct packed {
		logic [GRP_MAX-1:0][7:0] data;
		logic [GCW-1:0]          cnt;
		logic                    last;
	} etd_grp_t;

endpackage

// File: src/etd_front.sv
module etd_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [7:0]        in_byte,
	input  logic              in_last,
	input  logic              q_full,
	output logic              push,
	output etd_pkg::etd_grp_t push_grp
);
	import etd_pkg::*;

	typedef enum logic [4:0] {
		PH_IDLE = 5'b00001,
		PH_BSL  = 5'b00010,
		PH_HEX1 = 5'b00100,
		PH_HEX2 = 5'b01000,
		PH_OCT  = 5'b10000
	} phase_t;

	function automatic logic is_hex(input logic [7:0] b);
		return (b >= CH_ZERO && b <= CH_NINE) || (b >= CH_LC_A && b <= CH_LC_F) ||
			(b >= CH_UC_A && b <= CH_UC_F);
	endfunction

	// letters sit at low nibble 1..6 in both cases
	function automatic logic [3:0] hex_val(input logic [7:0] b);
		return (b <= CH_NINE) ? b[3:0] : b[3:0] + 4'd9;
	endfunction

	function automatic logic is_oct(input logic [7:0] b);
		return b >= CH_ZERO && b <= CH_SEVEN;
	endfunction

	phase_t     ph_q, ph_n;
	logic [7:0] held_q, held_n;
	logic [8:0] acc_q, acc_n;
	logic [1:0] dig_q, dig_n;
	logic       accept;
	etd_grp_t   grp;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;

	always_comb begin
		logic [GCW-1:0] n;
		logic [8:0]     oct_acc;
		logic [1:0]     dig_inc;
		n        = '0;
		oct_acc  = {acc_q[5:0], in_byte[2:0]};
		dig_inc  = dig_q + 2'd1;
		grp.data = '0;
		ph_n     = PH_IDLE;
		held_n   = held_q;
		acc_n    = acc_q;
		dig_n    = dig_q;
		unique case (ph_q)
			PH_BSL: begin
				unique case (in_byte)
					CH_BSL: begin
						grp.data[n[GIW-1:0]] = CH_BSL; n = n + 1'b1;
					end
					CH_QUOTE: begin
						grp.data[n[GIW-1:0]] = CH_QUOTE; n = n + 1'b1;
					end
					CH_LC_N: begin
						grp.data[n[GIW-1:0]] = BYTE_LF; n = n + 1'b1;
					end
					CH_LC_R: begin
						grp.data[n[GIW-1:0]] = BYTE_CR; n = n + 1'b1;
					end
					CH_LC_T: begin
						grp.data[n[GIW-1:0]] = BYTE_TAB; n = n + 1'b1;
					end
					CH_LC_E: begin
						grp.data[n[GIW-1:0]] = BYTE_ESC; n = n + 1'b1;
					end
					CH_LC_X: begin
						if (in_last) begin
							grp.data[n[GIW-1:0]] = CH_BSL; n = n + 1'b1;
							grp.data[n[GIW-1:0]] = CH_LC_X; n = n + 1'b1;
						end else begin
							ph_n = PH_HEX1;
						end
					end
					default: begin
						if (is_oct(in_byte)) begin
							acc_n = {6'd0, in_byte[2:0]};
							dig_n = 2'd1;
							if (in_last) begin
								grp.data[n[GIW-1:0]] = {5'd0, in_byte[2:0]}; n = n + 1'b1;
							end else begin
								ph_n = PH_OCT;
							end
						end else begin
							// unknown escape keeps both bytes
							grp.data[n[GIW-1:0]] = CH_BSL; n = n + 1'b1;
							grp.data[n[GIW-1:0]] = in_byte; n = n + 1'b1;
						end
					end
				endcase
			end
			PH_HEX1: begin
				if (!in_last && is_hex(in_byte)) begin
					held_n = in_byte;
					ph_n   = PH_HEX2;
				end else begin
					grp.data[n[GIW-1:0]] = CH_BSL; n = n + 1'b1;
					grp.data[n[GIW-1:0]] = CH_LC_X; n = n + 1'b1;
					if (in_byte == CH_BSL && !in_last) begin
						ph_n = PH_BSL;
					end else begin
						grp.data[n[GIW-1:0]] = in_byte; n = n + 1'b1;
					end
				end
			end
			PH_HEX2: begin
				if (is_hex(in_byte) && is_hex(held_q)) begin
					grp.data[n[GIW-1:0]] = {hex_val(held_q), hex_val(in_byte)}; n = n + 1'b1;
				end else begin
					grp.data[n[GIW-1:0]] = CH_BSL; n = n + 1'b1;
					grp.data[n[GIW-1:0]] = CH_LC_X; n = n + 1'b1;
					grp.data[n[GIW-1:0]] = held_q; n = n + 1'b1;
					if (in_byte == CH_BSL && !in_last) begin
						ph_n = PH_BSL;
					end else begin
						grp.data[n[GIW-1:0]] = in_byte; n = n + 1'b1;
					end
				end
			end
			PH_OCT: begin
				if (is_oct(in_byte)) begin
					acc_n = oct_acc;
					dig_n = dig_inc;
					if (dig_inc == 2'd3 || in_last) begin
						grp.data[n[GIW-1:0]] = oct_acc[7:0]; n = n + 1'b1;
					end else begin
						ph_n = PH_OCT;
					end
				end else begin
					grp.data[n[GIW-1:0]] = acc_q[7:0]; n = n + 1'b1;
					if (in_byte == CH_BSL && !in_last) begin
						ph_n = PH_BSL;
					end else begin
						grp.data[n[GIW-1:0]] = in_byte; n = n + 1'b1;
					end
				end
			end
			default: begin
				if (in_byte == CH_BSL && !in_last) begin
					ph_n = PH_BSL;
				end else begin
					grp.data[n[GIW-1:0]] = in_byte; n = n + 1'b1;
				end
			end
		endcase
		if (in_last) begin
			ph_n   = PH_IDLE;
			held_n = '0;
			acc_n  = '0;
			dig_n  = '0;
		end
		grp.cnt  = n;
		grp.last = in_last;
	end

	assign push     = accept && (grp.cnt != '0);
	assign push_grp = grp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q   <= PH_IDLE;
			held_q <= '0;
			acc_q  <= '0;
			dig_q  <= '0;
		end else if (accept) begin
			ph_q   <= ph_n;
			held_q <= held_n;
			acc_q  <= acc_n;
			dig_q  <= dig_n;
		end
	end

endmodule

// File: src/etd_queue.sv
module etd_queue #(
	parameter int unsigned DEPTH = etd_pkg::QUEUE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  etd_pkg::etd_grp_t push_grp,
	output logic              full,
	input  logic              pop,
	output logic              valid,
	output etd_pkg::etd_grp_t head
);
	import etd_pkg::*;

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	etd_grp_t        mem_q [DEPTH];
	logic [PW-1:0]   wr_q, rd_q;
	logic [CW-1:0]   cnt_q;

	assign full  = cnt_q == CW'(DEPTH);
	assign valid = cnt_q != '0;
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_grp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// File: src/etd_back.sv
module etd_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	input  etd_pkg::etd_grp_t q_head,
	output logic              q_pop,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [7:0]        out_byte,
	output logic              out_last,
	output logic              utf8_ok
);
	import etd_pkg::*;

	logic [GIW-1:0] idx_q;
	logic [1:0]     cont_q, cont_n;
	logic [2:0]     seq_q, seq_n;
	logic [CPW-1:0] code_q, code_n, code_sh;
	logic           inv_q, inv_n;
	logic           ov_q, ol_q, ok_q;
	logic [7:0]     ob_q;
	logic           load, take, grp_end, txt_end, ok_n;
	logic [7:0]     cur;

	assign load    = !ov_q || !out_stall;
	assign take    = q_valid && load;
	assign cur     = q_head.data[idx_q];
	assign grp_end = (GCW'(idx_q) + GCW'(1)) == q_head.cnt;
	assign txt_end = grp_end && q_head.last;
	assign q_pop   = take && grp_end;
	assign code_sh = {code_q[CPW-7:0], cur[5:0]};

	// one byte through the validator
	always_comb begin
		cont_n = cont_q;
		seq_n  = seq_q;
		code_n = code_q;
		inv_n  = inv_q;
		if (cont_q == 2'd0) begin
			if (cur <= ASCII_MAX) begin
				inv_n = inv_q;
			end else if (cur >= LEAD2_MIN && cur <= LEAD2_MAX) begin
				seq_n  = 3'd2;
				code_n = CPW'(cur[4:0]);
				cont_n = 2'd1;
			end else if (cur >= LEAD3_MIN && cur <= LEAD3_MAX) begin
				seq_n  = 3'd3;
				code_n = CPW'(cur[3:0]);
				cont_n = 2'd2;
			end else if (cur >= LEAD4_MIN && cur <= LEAD4_MAX) begin
				seq_n  = 3'd4;
				code_n = CPW'(cur[2:0]);
				cont_n = 2'd3;
			end else begin
				inv_n = 1'b1;
			end
		end else if ((cur & CONT_MASK) != CONT_TAG) begin
			inv_n  = 1'b1;
			cont_n = 2'd0;
		end else begin
			code_n = code_sh | CPW'(cur & CONT_BITS);
			cont_n = cont_q - 2'd1;
			if (cont_n == 2'd0) begin
				if ((seq_q == 3'd3 && code_n < CP_MIN3) ||
					(seq_q == 3'd4 && code_n < CP_MIN4) ||
					(code_n >= SURR_LO && code_n <= SURR_HI) ||
					code_n > CP_MAX) begin
					inv_n = 1'b1;
				end
			end
		end
	end

	// a sequence still open at the end counts as truncated
	assign ok_n = !(inv_n || cont_n != 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= '0;
			cont_q <= '0;
			seq_q  <= '0;
			code_q <= '0;
			inv_q  <= 1'b0;
			ov_q   <= 1'b0;
		end else begin
			if (load) begin
				ov_q <= take;
			end
			if (take) begin
				idx_q <= grp_end ? '0 : idx_q + 1'b1;
				if (txt_end) begin
					cont_q <= '0;
					seq_q  <= '0;
					code_q <= '0;
					inv_q  <= 1'b0;
				end else begin
					cont_q <= cont_n;
					seq_q  <= seq_n;
					code_q <= code_n;
					inv_q  <= inv_n;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			ob_q <= cur;
			ol_q <= txt_end;
			ok_q <= txt_end && ok_n;
		end
	end

	assign out_valid = ov_q;
	assign out_byte  = ob_q;
	assign out_last  = ol_q;
	assign utf8_ok   = ok_q;

endmodule

// File: src/escape_text_decoder_utf8_check_top.sv
// Escaped-text decoder with UTF-8 check. One escaped byte is taken per cycle
// while the group queue (QUEUE_DEPTH groups) has room; each byte decodes at
// once into zero to four output bytes that enter the queue as one group. The
// output side sends one decoded byte per cycle, while out_stall is low, through a
// single output register, and in_stall rises only when the queue is full. The
// decoded bytes of an accepted byte pass through the queue and then the output
// register. The transaction that carries out_last also carries utf8_ok for the
// whole text; every text ends with at least one output transaction.
module escape_text_decoder_utf8_check_top #(
	parameter int unsigned QUEUE_DEPTH = etd_pkg::QUEUE_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       out_last,
	output logic       utf8_ok
);
	import etd_pkg::*;

	logic     push, q_full, q_valid, q_pop;
	etd_grp_t push_grp, q_head;

	etd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_byte  (in_byte),
		.in_last  (in_last),
		.q_full   (q_full),
		.push     (push),
		.push_grp (push_grp)
	);

	etd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_grp (push_grp),
		.full     (q_full),
		.pop      (q_pop),
		.valid    (q_valid),
		.head     (q_head)
	);

	etd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_byte  (out_byte),
		.out_last  (out_last),
		.utf8_ok   (utf8_ok)
	);

endmodule

// File: src/etd_check.sv
module etd_check (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic [7:0] in_byte,
	input logic       in_last,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] out_byte,
	input logic       out_last,
	input logic       utf8_ok
);

	// a waiting input transaction holds its payload
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(in_byte) && $stable(in_last))
		else $error("input transaction changed while stalled");

	// a waiting transaction holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_byte) &&
			$stable(out_last) && $stable(utf8_ok))
		else $error("output transaction changed while stalled");

	// the verdict only travels with the end of a text
	a_ok_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && utf8_ok |-> out_last)
		else $error("utf8_ok set on a non-final byte");

	// the queue fills only through an accepted input byte
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_stall) |-> $past(in_valid && !in_stall))
		else $error("in_stall rose without an accepted input");

endmodule

bind escape_text_decoder_utf8_check_top etd_check u_etd_check (.*);

// File: tb/tb_escape_text_decoder_utf8_check_top.sv
module tb_escape_text_decoder_utf8_check_top;
	timeunit 1ns;
	timeprecision 1ps;
	import etd_pkg::*;

	typedef enum logic [2:0] {
		ESC_IDLE,
		ESC_BSL,
		ESC_HEX0,
		ESC_HEX1,
		ESC_OCT
	} esc_state_t;

	typedef struct packed {
		logic [7:0] b;
		logic       last;
		logic       ok;
	} dec_out_t;

	typedef struct packed {
		logic [7:0] b;
		logic       last;
		logic       drain;
	} text_byte_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] in_byte = 8'h00;
	logic       in_last = 1'b0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] out_byte;
	logic       out_last;
	logic       utf8_ok;

	// decoder state mirrored by the predictor
	esc_state_t  esc_state;
	logic [7:0]  held_hex;
	logic [8:0]  oct_acc;
	logic [1:0]  oct_cnt;
	logic [1:0]  cont_left;
	logic [2:0]  seq_w;
	logic [20:0] cp_acc;
	logic        bad;

	dec_out_t   decoded_q[$];
	text_byte_t escaped_q[$];
	logic [7:0] text_buf[$];

	logic in_taken;
	logic out_taken;
	int   in_gap = 0;
	int   out_hold = 0;
	int   calm_in = 0;
	int   calm_out = 0;
	int   mismatches = 0;

	escape_text_decoder_utf8_check_top i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_byte(in_byte),
		.in_last(in_last),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_byte(out_byte),
		.out_last(out_last),
		.utf8_ok(utf8_ok)
	);

	always #5 clk = ~clk;

	function automatic void clear_decoder();
		esc_state = ESC_IDLE;
		held_hex = 8'h00;
		oct_acc = 9'h000;
		oct_cnt = 2'd0;
		cont_left = 2'd0;
		seq_w = 3'd0;
		cp_acc = 21'h0;
		bad = 1'b0;
	endfunction

	function automatic int hex_val(logic [7:0] c);
		if (c >= CH_ZERO && c <= CH_NINE) return int'(c - CH_ZERO);
		if (c >= CH_LC_A && c <= CH_LC_F) return int'(c - CH_LC_A) + 10;
		if (c >= CH_UC_A && c <= CH_UC_F) return int'(c - CH_UC_A) + 10;
		return -1;
	endfunction

	function automatic void utf8_track(logic [7:0] b);
		if (cont_left == 2'd0) begin
			if (b > ASCII_MAX) begin
				if (b >= LEAD2_MIN && b <= LEAD2_MAX) begin
					seq_w = 3'd2;
					cp_acc = {16'h0, b[4:0]};
					cont_left = 2'd1;
				end else if (b >= LEAD3_MIN && b <= LEAD3_MAX) begin
					seq_w = 3'd3;
					cp_acc = {17'h0, b[3:0]};
					cont_left = 2'd2;
				end else if (b >= LEAD4_MIN && b <= LEAD4_MAX) begin
					seq_w = 3'd4;
					cp_acc = {18'h0, b[2:0]};
					cont_left = 2'd3;
				end else begin
					bad = 1'b1;
				end
			end
		end else if ((b & CONT_MASK) != CONT_TAG) begin
			bad = 1'b1;
			cont_left = 2'd0;
		end else begin
			cp_acc = {cp_acc[14:0], b[5:0]};
			cont_left = cont_left - 2'd1;
			if (cont_left == 2'd0 &&
					((seq_w == 3'd3 && cp_acc < CP_MIN3) ||
					(seq_w == 3'd4 && cp_acc < CP_MIN4) ||
					(cp_acc >= SURR_LO && cp_acc <= SURR_HI) ||
					cp_acc > CP_MAX))
				bad = 1'b1;
		end
	endfunction

	function automatic void emit_byte(logic [7:0] b);
		dec_out_t r;
		r = {b, 2'b00};
		decoded_q.insert(decoded_q.size(), r);
		utf8_track(b);
	endfunction

	function automatic void plain_byte(logic [7:0] b, logic last);
		if (b == CH_BSL && !last) esc_state = ESC_BSL;
		else emit_byte(b);
	endfunction

	// expected decoded bytes for one accepted escaped byte
	function automatic void decode_byte(logic [7:0] b, logic last);
		esc_state_t st;
		int         n0;
		int         hi;
		int         lo;
		dec_out_t   r;
		st = esc_state;
		n0 = decoded_q.size();
		esc_state = ESC_IDLE;
		case (st)
			ESC_BSL: begin
				case (b)
					CH_BSL: emit_byte(CH_BSL);
					CH_QUOTE: emit_byte(CH_QUOTE);
					CH_LC_N: emit_byte(BYTE_LF);
					CH_LC_R: emit_byte(BYTE_CR);
					CH_LC_T: emit_byte(BYTE_TAB);
					CH_LC_E: emit_byte(BYTE_ESC);
					CH_LC_X: begin
						if (last) begin
							emit_byte(CH_BSL);
							emit_byte(CH_LC_X);
						end else begin
							esc_state = ESC_HEX0;
						end
					end
					default: begin
						if (b >= CH_ZERO && b <= CH_SEVEN) begin
							oct_acc = {6'h0, b[2:0]};
							oct_cnt = 2'd1;
							if (last) emit_byte(oct_acc[7:0]);
							else esc_state = ESC_OCT;
						end else begin
							emit_byte(CH_BSL);
							emit_byte(b);
						end
					end
				endcase
			end
			ESC_HEX0: begin
				if (!last && hex_val(b) >= 0) begin
					held_hex = b;
					esc_state = ESC_HEX1;
				end else begin
					emit_byte(CH_BSL);
					emit_byte(CH_LC_X);
					plain_byte(b, last);
				end
			end
			ESC_HEX1: begin
				lo = hex_val(b);
				hi = hex_val(held_hex);
				if (lo >= 0 && hi >= 0) begin
					emit_byte(8'(hi * 16 + lo));
				end else begin
					emit_byte(CH_BSL);
					emit_byte(CH_LC_X);
					emit_byte(held_hex);
					plain_byte(b, last);
				end
			end
			ESC_OCT: begin
				if (b >= CH_ZERO && b <= CH_SEVEN) begin
					oct_acc = {oct_acc[5:0], b[2:0]};
					oct_cnt = oct_cnt + 2'd1;
					if (oct_cnt == 2'd3 || last) emit_byte(oct_acc[7:0]);
					else esc_state = ESC_OCT;
				end else begin
					emit_byte(oct_acc[7:0]);
					plain_byte(b, last);
				end
			end
			default: plain_byte(b, last);
		endcase
		if (last) begin
			if (cont_left != 2'd0) bad = 1'b1;
			if (decoded_q.size() > n0) begin
				r = decoded_q.pop_back();
				r.last = 1'b1;
				r.ok = !bad;
				decoded_q.insert(decoded_q.size(), r);
			end
			clear_decoder();
		end
	endfunction

	function automatic void check_output(logic [7:0] b, logic last, logic ok);
		dec_out_t e;
		if (decoded_q.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected output: byte %02h last %0b ok %0b", b, last, ok);
		end else begin
			e = decoded_q.pop_front();
			if (e.b !== b || e.last !== last || e.ok !== ok) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: expected byte %02h last %0b ok %0b, got byte %02h last %0b ok %0b",
						e.b, e.last, e.ok, b, last, ok);
			end
		end
	endfunction

	// mostly random waits, with occasional stretches of back-to-back traffic
	function automatic int pick_wait(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 24) == 0) begin
			calm = $urandom_range(8, 40);
			return 0;
		end
		return $urandom_range(0, 17);
	endfunction

	function automatic void put_char(logic [7:0] c);
		text_buf.insert(text_buf.size(), c);
	endfunction

	function automatic logic [7:0] hex_char(logic [3:0] v, bit upper);
		if (v < 4'd10) return CH_ZERO + 8'(v);
		return (upper ? CH_UC_A : CH_LC_A) + 8'(v) - 8'd10;
	endfunction

	function automatic void push_hex(logic [7:0] b);
		put_char(CH_BSL);
		put_char(CH_LC_X);
		put_char(hex_char(b[7:4], 1'($urandom)));
		put_char(hex_char(b[3:0], 1'($urandom)));
	endfunction

	// one decoded byte written raw, as a hex escape or as a full octal escape
	function automatic void push_coded(logic [7:0] b);
		case ($urandom_range(0, 3))
			0: push_hex(b);
			1: begin
				put_char(CH_BSL);
				put_char(CH_ZERO + 8'(b[7:6]));
				put_char(CH_ZERO + 8'(b[5:3]));
				put_char(CH_ZERO + 8'(b[2:0]));
			end
			default: begin
				if (b == CH_BSL) push_hex(b);
				else put_char(b);
			end
		endcase
	endfunction

	// keep below w gives a truncated sequence
	function automatic void push_utf8(logic [20:0] cp, int w, int keep);
		logic [7:0] lead;
		case (w)
			2: lead = 8'hc0 | 8'(cp[10:6]);
			3: lead = 8'he0 | 8'(cp[15:12]);
			default: lead = 8'hf0 | 8'(cp[20:18]);
		endcase
		push_coded(lead);
		for (int i = 1; i < keep; i++)
			push_coded(CONT_TAG | 8'((cp >> (6 * (w - 1 - i))) & 21'h3f));
	endfunction

	function automatic void add_token();
		int          w;
		logic [20:0] cp;
		logic [7:0]  b;
		case ($urandom_range(0, 9))
			0, 1: begin
				b = 8'($urandom_range(32, 126));
				if (b == CH_BSL) put_char(CH_BSL);
				put_char(b);
			end
			2: begin
				put_char(CH_BSL);
				case ($urandom_range(0, 5))
					0: put_char(CH_BSL);
					1: put_char(CH_QUOTE);
					2: put_char(CH_LC_N);
					3: put_char(CH_LC_R);
					4: put_char(CH_LC_T);
					default: put_char(CH_LC_E);
				endcase
			end
			3: push_hex(8'($urandom));
			4: begin
				put_char(CH_BSL);
				w = $urandom_range(1, 3);
				for (int i = 0; i < w; i++)
					put_char(CH_ZERO + 8'($urandom_range(0, 7)));
			end
			5, 6: begin
				w = $urandom_range(2, 4);
				case (w)
					2: cp = 21'($urandom_range(32'h80, 32'h7ff));
					3: begin
						cp = 21'($urandom_range(32'h800, 32'hffff));
						if (cp >= SURR_LO && cp <= SURR_HI) cp = cp ^ 21'h2000;
					end
					default: cp = 21'($urandom_range(32'h10000, 32'h10ffff));
				endcase
				push_utf8(cp, w, w);
			end
			7: begin
				case ($urandom_range(0, 2))
					0: begin
						if ($urandom_range(0, 1) == 0) b = 8'($urandom_range(8'h80, 8'hc1));
						else b = 8'($urandom_range(8'hf5, 8'hff));
						push_coded(b);
					end
					1: begin
						if ($urandom_range(0, 1) == 0)
							push_utf8(21'($urandom_range(32'hd800, 32'hdfff)), 3, 3);
						else
							push_utf8(21'($urandom_range(32'h110000, 32'h13ffff)), 4, 4);
					end
					default: begin
						w = $urandom_range(2, 4);
						cp = 21'($urandom) >> $urandom_range(0, 20);
						push_utf8(cp, w, $urandom_range(1, w));
					end
				endcase
			end
			8: begin
				// escapes that break off or go wrong
				put_char(CH_BSL);
				case ($urandom_range(0, 4))
					0: put_char(8'($urandom));
					1: begin
						put_char(CH_LC_X);
						put_char(hex_char(4'($urandom), 1'($urandom)));
						put_char(8'($urandom));
					end
					2: begin
						put_char(CH_LC_X);
						put_char(8'($urandom));
					end
					3: put_char(CH_LC_X);
					default: ;
				endcase
			end
			default: put_char(8'($urandom));
		endcase
	endfunction

	function automatic void flush_text(bit drain);
		text_byte_t e;
		foreach (text_buf[i]) begin
			e = {text_buf[i], i == text_buf.size() - 1, drain && i == 0};
			escaped_q.insert(escaped_q.size(), e);
		end
		text_buf.delete();
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_taken <= 1'b0;
			out_taken <= 1'b0;
		end else begin
			in_taken <= in_valid && !in_stall;
			out_taken <= out_valid && !out_stall;
			if (in_valid && !in_stall) decode_byte(in_byte, in_last);
			if (out_valid && !out_stall) check_output(out_byte, out_last, utf8_ok);
		end
	end

	always @(negedge clk) begin
		text_byte_t it;
		if (arst_n) begin
			if (in_valid && !in_taken) begin
				// transaction still pending, hold it
			end else if (in_gap != 0) begin
				in_valid <= 1'b0;
				in_gap <= in_gap - 1;
			end else if (escaped_q.size() != 0 &&
					!(escaped_q[0].drain && decoded_q.size() != 0)) begin
				it = escaped_q.pop_front();
				in_valid <= 1'b1;
				in_byte <= it.b;
				in_last <= it.last;
				in_gap <= pick_wait(calm_in);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		int w;
		if (arst_n) begin
			w = out_hold;
			if (out_taken) w = pick_wait(calm_out);
			if (w > 0) begin
				out_stall <= 1'b1;
				out_hold <= out_valid ? w - 1 : w;
			end else begin
				out_stall <= 1'b0;
				out_hold <= 0;
			end
		end
	end

	initial begin
		int n_items;
		int n_tok;
		bit first_random;
		clear_decoder();

		// simple escapes, unknown escape, escaped backslash on the last byte
		text_buf = '{8'h00, CH_BSL, CH_LC_N, CH_BSL, CH_QUOTE, CH_BSL, CH_LC_T,
			CH_BSL, CH_LC_E, CH_BSL, 8'h71, CH_BSL, CH_BSL};
		flush_text(1'b0);
		// hex, octal wrapping past 0xff, trailing backslash
		text_buf = '{CH_BSL, CH_LC_X, 8'h34, CH_LC_F, CH_BSL, CH_SEVEN, CH_SEVEN, CH_SEVEN,
			CH_BSL};
		flush_text(1'b1);
		// malformed hex then a raw 0xff as last byte
		text_buf = '{CH_BSL, CH_LC_X, 8'h67, 8'hff};
		flush_text(1'b0);

		n_items = 0;
		first_random = 1'b1;
		while (n_items < 360) begin
			n_tok = $urandom_range(1, 5);
			for (int t = 0; t < n_tok; t++) add_token();
			n_items += text_buf.size();
			flush_text(first_random || $urandom_range(0, 29) == 0);
			first_random = 1'b0;
		end

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		wait (escaped_q.size() == 0 && !in_valid);
		wait (decoded_q.size() == 0);
		repeat (20) @(posedge clk);
		if (decoded_q.size() != 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0d decoded bytes never arrived", decoded_q.size());
		end
		if (mismatches == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	initial begin
		#4_000_000;
		$display("Verification failed");
		$finish;
	end

endmodule
